[rtl/core/clkcal_pkg.sv]
// ----------------------------------------------------------------------------
// clkcal_pkg
// Types, codes and helper functions shared by the clock calendar counter.
// ----------------------------------------------------------------------------
package clkcal_pkg;

   // Operation carried by one request word.
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SET  = 1'b1
   } opcode_type;

   // Field group selected by a set operation.
   typedef enum logic {
      ROW_TIME = 1'b0,
      ROW_DATE = 1'b1
   } row_type;

   // Digit positions within a row.
   localparam logic [2:0] COL_FIRST_TENS   = 3'd0;
   localparam logic [2:0] COL_FIRST_UNITS  = 3'd1;
   localparam logic [2:0] COL_SEP_A        = 3'd2;
   localparam logic [2:0] COL_SECOND_TENS  = 3'd3;
   localparam logic [2:0] COL_SECOND_UNITS = 3'd4;
   localparam logic [2:0] COL_SEP_B        = 3'd5;
   localparam logic [2:0] COL_THIRD_TENS   = 3'd6;
   localparam logic [2:0] COL_THIRD_UNITS  = 3'd7;

   // Field limits.
   localparam logic [4:0] HOUR_MAX  = 5'd23;
   localparam logic [5:0] MIN_MAX   = 6'd59;
   localparam logic [5:0] SEC_MAX   = 6'd59;
   localparam logic [3:0] MONTH_MAX = 4'd12;
   localparam logic [6:0] YEAR_MAX  = 7'd99;
   localparam logic [4:0] LEAP_FEB  = 5'd29;
   localparam logic [4:0] LONG_DAYS = 5'd31;
   localparam logic [3:0] FEBRUARY  = 4'd2;

   // Days per month, January first.
   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // One decoded request word.
   typedef struct packed {
      opcode_type opcode;
      row_type    row;
      logic [2:0] column;
      logic [3:0] digit;
   } cmd_type;

   // Complete clock and calendar state.
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } calendar_type;

   // Reset value of the calendar: midnight, first of January, year zero.
   localparam calendar_type CAL_RESET = '{
      hours: 5'd0, minutes: 6'd0, seconds: 6'd0,
      day: 5'd1, month: 4'd1, year: 7'd0
   };

   // Length of a month; February gets one more day when the year is a
   // multiple of four. Months outside the legal range read as 31 days.
   function automatic logic [4:0] days_in(logic [3:0] month, logic [6:0] year);
      logic [4:0] len;
      if (month == FEBRUARY && year[1:0] == 2'b00) begin
         len = LEAP_FEB;
      end else if (month >= 4'd1 && month <= MONTH_MAX) begin
         len = MONTH_DAYS[month - 4'd1];
      end else begin
         len = LONG_DAYS;
      end
      return len;
   endfunction

   // Replace the tens or units decimal digit of a value below 100. The
   // quotient by ten uses the reciprocal 205/2048, exact over this range.
   function automatic logic [7:0] put_digit(logic [6:0] value, logic tens_pos,
                                            logic [3:0] digit);
      logic [14:0] prod;
      logic [3:0]  quo;
      logic [3:0]  rem;
      logic [7:0]  res;
      prod = 15'(value) * 15'd205;
      quo  = prod[14:11];
      rem  = 4'(value - 7'(({3'b000, quo} << 3) + ({3'b000, quo} << 1)));
      if (tens_pos) begin
         res = ({4'b0000, digit} << 3) + ({4'b0000, digit} << 1) + {4'b0000, rem};
      end else begin
         res = ({4'b0000, quo} << 3) + ({4'b0000, quo} << 1) + {4'b0000, digit};
      end
      return res;
   endfunction

endpackage

[rtl/core/clock_calendar_counter_core.sv]
// ----------------------------------------------------------------------------
// clock_calendar_counter_core
// Real-time clock and calendar with tick and digit-set requests.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one word per operation: a one-second tick or a
//   set of one decimal digit of the field chosen by row and column. Every
//   req word yields exactly one rsp word holding all six current values
//   (hours, minutes, seconds, day, month, year) after the operation.
//   A req word is captured in an input register; from there it updates the
//   calendar registers, which also drive the rsp payload, as soon as the
//   rsp slot is empty or its word is being taken. One word per cycle is
//   sustained while the receiver keeps taking rsp words: req_ready stays
//   high while the rsp word is being taken.
//   When the receiver stalls, the calendar holds and the rsp payload stays
//   fixed; one more req word is buffered in the input register, after
//   which req_ready drops until rsp_ready returns.
//   Synchronous reset sets the time to 00:00:00, the date to day 1,
//   month 1, year 0, and empties both channels.
// ----------------------------------------------------------------------------
module clock_calendar_counter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic       req_row,
   input  logic [2:0] req_column,
   input  logic [3:0] req_digit,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_hours,
   output logic [5:0] rsp_minutes,
   output logic [5:0] rsp_seconds,
   output logic [4:0] rsp_day_of_month,
   output logic [3:0] rsp_month_number,
   output logic [6:0] rsp_year_of_century
);
   import clkcal_pkg::*;

   cmd_type      cmd_ff;
   cmd_type      cmd_in;
   logic         cmd_valid_ff;
   logic         cmd_valid_in;
   calendar_type cal_ff;
   calendar_type cal_in;
   calendar_type cal_next;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         advance;

   // A buffered word moves on when the result slot is empty or being taken.
   assign advance   = cmd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cmd_valid_ff || advance;

   // Input register control.
   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      if (req_ready) begin
         cmd_valid_in = req_valid;
         if (req_valid) begin
            cmd_in.opcode = opcode_type'(req_opcode);
            cmd_in.row    = row_type'(req_row);
            cmd_in.column = req_column;
            cmd_in.digit  = req_digit;
         end
      end
   end

   clkcal_update u_update (
      .cmd (cmd_ff),
      .cur (cal_ff),
      .nxt (cal_next)
   );

   // Calendar registers double as the result register.
   always_comb begin
      cal_in       = advance ? cal_next : cal_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cal_ff       <= CAL_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cal_ff       <= cal_in;
      end
   end

   // Input payload needs no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hours           = cal_ff.hours;
   assign rsp_minutes         = cal_ff.minutes;
   assign rsp_seconds         = cal_ff.seconds;
   assign rsp_day_of_month    = cal_ff.day;
   assign rsp_month_number    = cal_ff.month;
   assign rsp_year_of_century = cal_ff.year;

endmodule

[rtl/core/clkcal_update.sv]
// ----------------------------------------------------------------------------
// clkcal_update
// Next-state logic: one-second tick with cascaded rollover, or digit set
// followed by clamping of the selected row.
// ----------------------------------------------------------------------------
module clkcal_update (
   input  clkcal_pkg::cmd_type      cmd,
   input  clkcal_pkg::calendar_type cur,
   output clkcal_pkg::calendar_type nxt
);
   import clkcal_pkg::*;

   calendar_type tick_val;
   calendar_type set_val;

   logic sec_wrap;
   logic min_wrap;
   logic hour_wrap;
   logic day_wrap;
   logic month_wrap;

   logic [1:0] field_sel;
   logic       tens_pos;
   logic [6:0] field_cur;
   logic [7:0] field_new;

   logic [7:0] raw_first;
   logic [7:0] raw_second;
   logic [7:0] raw_third;
   logic [3:0] month_clamped;
   logic [6:0] year_clamped;
   logic [4:0] month_len;
   logic [4:0] day_clamped;

   // Tick: a field wraps at its limit, but only when the one below it wraps too.
   always_comb begin
      sec_wrap   = (cur.seconds == SEC_MAX);
      min_wrap   = sec_wrap && (cur.minutes == MIN_MAX);
      hour_wrap  = min_wrap && (cur.hours == HOUR_MAX);
      day_wrap   = hour_wrap && (cur.day == days_in(cur.month, cur.year));
      month_wrap = day_wrap && (cur.month == MONTH_MAX);

      tick_val.seconds = sec_wrap ? 6'd0 : cur.seconds + 6'd1;
      tick_val.minutes = min_wrap ? 6'd0 : (sec_wrap ? cur.minutes + 6'd1 : cur.minutes);
      tick_val.hours   = hour_wrap ? 5'd0 : (min_wrap ? cur.hours + 5'd1 : cur.hours);
      tick_val.day     = day_wrap ? 5'd1 : (hour_wrap ? cur.day + 5'd1 : cur.day);
      tick_val.month   = month_wrap ? 4'd1 : (day_wrap ? cur.month + 4'd1 : cur.month);
      if (month_wrap) begin
         tick_val.year = (cur.year == YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
      end else begin
         tick_val.year = cur.year;
      end
   end

   // Set: decode the digit position. Field select 3 means a separator.
   always_comb begin
      unique case (cmd.column)
         COL_FIRST_TENS, COL_FIRST_UNITS:   field_sel = 2'd0;
         COL_SECOND_TENS, COL_SECOND_UNITS: field_sel = 2'd1;
         COL_THIRD_TENS, COL_THIRD_UNITS:   field_sel = 2'd2;
         default:                           field_sel = 2'd3;
      endcase
      tens_pos = (cmd.column == COL_FIRST_TENS) || (cmd.column == COL_SECOND_TENS) ||
                 (cmd.column == COL_THIRD_TENS);
   end

   // Set: pick the current value of the addressed field and patch one digit.
   always_comb begin
      if (cmd.row == ROW_TIME) begin
         case (field_sel)
            2'd0:    field_cur = {2'b00, cur.hours};
            2'd1:    field_cur = {1'b0, cur.minutes};
            default: field_cur = {1'b0, cur.seconds};
         endcase
      end else begin
         case (field_sel)
            2'd0:    field_cur = {3'b000, cur.month};
            2'd1:    field_cur = {2'b00, cur.day};
            default: field_cur = cur.year;
         endcase
      end
      field_new = put_digit(field_cur, tens_pos, cmd.digit);
   end

   // Set: build raw field values, then clamp the addressed row.
   always_comb begin
      if (cmd.row == ROW_TIME) begin
         raw_first  = {3'b000, cur.hours};
         raw_second = {2'b00, cur.minutes};
         raw_third  = {2'b00, cur.seconds};
      end else begin
         raw_first  = {4'b0000, cur.month};
         raw_second = {3'b000, cur.day};
         raw_third  = {1'b0, cur.year};
      end
      if (field_sel == 2'd0) raw_first  = field_new;
      if (field_sel == 2'd1) raw_second = field_new;
      if (field_sel == 2'd2) raw_third  = field_new;

      // Date clamping: month first, then year, then day against the month.
      if (raw_first > {4'b0000, MONTH_MAX}) begin
         month_clamped = MONTH_MAX;
      end else if (raw_first == 8'd0) begin
         month_clamped = 4'd1;
      end else begin
         month_clamped = raw_first[3:0];
      end
      year_clamped = (raw_third > {1'b0, YEAR_MAX}) ? YEAR_MAX : raw_third[6:0];
      month_len    = days_in(month_clamped, year_clamped);
      if (raw_second > {3'b000, month_len}) begin
         day_clamped = month_len;
      end else if (raw_second == 8'd0) begin
         day_clamped = 5'd1;
      end else begin
         day_clamped = raw_second[4:0];
      end

      set_val = cur;
      if (cmd.row == ROW_TIME) begin
         set_val.hours   = (raw_first > {3'b000, HOUR_MAX}) ? HOUR_MAX : raw_first[4:0];
         set_val.minutes = (raw_second > {2'b00, MIN_MAX}) ? MIN_MAX : raw_second[5:0];
         set_val.seconds = (raw_third > {2'b00, SEC_MAX}) ? SEC_MAX : raw_third[5:0];
      end else begin
         set_val.month = month_clamped;
         set_val.day   = day_clamped;
         set_val.year  = year_clamped;
      end
   end

   assign nxt = (cmd.opcode == OP_TICK) ? tick_val : set_val;

endmodule

[dv/tb_clock_calendar_counter_core.sv]
// ----------------------------------------------------------------------------
// tb_clock_calendar_counter_core
// Self-checking testbench for the clock calendar counter core. A queue of
// tick and digit-set words feeds a bursty driver, and a stalling receiver
// takes the response words. Every accepted request word runs through a
// behavioral calendar kept in the bench, and each response word is compared
// field by field with the oldest predicted calendar.
// ----------------------------------------------------------------------------
module tb_clock_calendar_counter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import clkcal_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_WORDS   = 750;
   localparam int MAX_PRINTED    = 25;

   // Receiver behavior; a new style is drawn whenever the current one runs out.
   typedef enum {RX_STREAM, RX_JITTER, RX_BLOCKING} rx_style_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = 1'b0;
   logic       req_row = 1'b0;
   logic [2:0] req_column = 3'd0;
   logic [3:0] req_digit = 4'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_hours;
   logic [5:0] rsp_minutes;
   logic [5:0] rsp_seconds;
   logic [4:0] rsp_day_of_month;
   logic [3:0] rsp_month_number;
   logic [6:0] rsp_year_of_century;

   cmd_type      pending_words[$];
   calendar_type expected_calendars[$];
   calendar_type clock_now;

   logic         req_fire = 1'b0;
   int           burst_left = 1;
   int           gap_left = 0;
   int           stall_left = 0;
   int           style_cycles = 0;
   rx_style_type rx_style = RX_STREAM;
   int           idle_cycles = 0;

   int error_count = 0;
   int checked_words = 0;
   int tick_count = 0;
   int set_count = 0;
   int day_rollovers = 0;
   int year_wraps = 0;

   clock_calendar_counter_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_row             (req_row),
      .req_column          (req_column),
      .req_digit           (req_digit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hours           (rsp_hours),
      .rsp_minutes         (rsp_minutes),
      .rsp_seconds         (rsp_seconds),
      .rsp_day_of_month    (rsp_day_of_month),
      .rsp_month_number    (rsp_month_number),
      .rsp_year_of_century (rsp_year_of_century)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Print one line per problem, up to a cap, and count every one.
   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // ------------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------------

   // Month length for a legal month; February is long in years divisible by four.
   function automatic int month_length(input int month, input int year);
      if (month == int'(FEBRUARY) && (year % 4) == 0) begin
         return int'(LEAP_FEB);
      end
      return int'(MONTH_DAYS[month - 1]);
   endfunction

   // Replace the tens or the units decimal digit of a value.
   function automatic int splice_digit(input int value, input bit tens_place,
                                       input int digit);
      if (tens_place) begin
         return 10 * digit + value % 10;
      end
      return 10 * (value / 10) + digit;
   endfunction

   // One-second tick with rollover through the whole calendar.
   task automatic advance_one_second();
      int sec;
      int mins;
      int hrs;
      int day;
      int mon;
      int yr;
      sec  = clock_now.seconds + 1;
      mins = clock_now.minutes;
      hrs  = clock_now.hours;
      day  = clock_now.day;
      mon  = clock_now.month;
      yr   = clock_now.year;
      if (sec >= 60) begin
         sec = 0;
         mins++;
         if (mins >= 60) begin
            mins = 0;
            hrs++;
            if (hrs >= 24) begin
               hrs = 0;
               day++;
               if (day > month_length(mon, yr)) begin
                  day = 1;
                  day_rollovers++;
                  mon++;
                  if (mon > 12) begin
                     mon = 1;
                     yr++;
                     if (yr > 99) begin
                        yr = 0;
                        year_wraps++;
                     end
                  end
               end
            end
         end
      end
      clock_now.seconds = 6'(sec);
      clock_now.minutes = 6'(mins);
      clock_now.hours   = 5'(hrs);
      clock_now.day     = 5'(day);
      clock_now.month   = 4'(mon);
      clock_now.year    = 7'(yr);
   endtask

   // Digit write into one field of the chosen row, then clamp that row.
   task automatic apply_digit_set(input row_type row, input logic [2:0] column,
                                  input logic [3:0] digit);
      bit separator;
      bit tens_place;
      int slot;
      int first;
      int second;
      int third;
      separator  = (column == COL_SEP_A) || (column == COL_SEP_B);
      tens_place = (column % 3) == 0;
      slot       = column / 3;
      if (row == ROW_TIME) begin
         first  = clock_now.hours;
         second = clock_now.minutes;
         third  = clock_now.seconds;
      end else begin
         first  = clock_now.month;
         second = clock_now.day;
         third  = clock_now.year;
      end
      if (!separator) begin
         case (slot)
            0: first  = splice_digit(first, tens_place, digit);
            1: second = splice_digit(second, tens_place, digit);
            default: third = splice_digit(third, tens_place, digit);
         endcase
      end
      if (row == ROW_TIME) begin
         clock_now.hours   = 5'((first > int'(HOUR_MAX)) ? int'(HOUR_MAX) : first);
         clock_now.minutes = 6'((second > int'(MIN_MAX)) ? int'(MIN_MAX) : second);
         clock_now.seconds = 6'((third > int'(SEC_MAX)) ? int'(SEC_MAX) : third);
      end else begin
         // Month first, then year, so the day sees the final month length.
         if (first > int'(MONTH_MAX)) first = int'(MONTH_MAX);
         if (first == 0) first = 1;
         if (third > int'(YEAR_MAX)) third = int'(YEAR_MAX);
         if (second > month_length(first, third)) second = month_length(first, third);
         if (second == 0) second = 1;
         clock_now.month = 4'(first);
         clock_now.day   = 5'(second);
         clock_now.year  = 7'(third);
      end
   endtask

   // Compare one response word with the oldest predicted calendar.
   task automatic check_response(input calendar_type got);
      calendar_type want;
      if (expected_calendars.size() == 0) begin
         flag_error("response word with no request outstanding");
         return;
      end
      want = expected_calendars.pop_front();
      checked_words++;
      if (got.hours !== want.hours)
         flag_error($sformatf("hours %0d, expected %0d", got.hours, want.hours));
      if (got.minutes !== want.minutes)
         flag_error($sformatf("minutes %0d, expected %0d", got.minutes, want.minutes));
      if (got.seconds !== want.seconds)
         flag_error($sformatf("seconds %0d, expected %0d", got.seconds, want.seconds));
      if (got.day !== want.day)
         flag_error($sformatf("day %0d, expected %0d", got.day, want.day));
      if (got.month !== want.month)
         flag_error($sformatf("month %0d, expected %0d", got.month, want.month));
      if (got.year !== want.year)
         flag_error($sformatf("year %0d, expected %0d", got.year, want.year));
   endtask

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------

   task automatic queue_set(input row_type row, input logic [2:0] column,
                            input logic [3:0] digit);
      cmd_type word;
      word.opcode = OP_SET;
      word.row    = row;
      word.column = column;
      word.digit  = digit;
      pending_words.push_back(word);
   endtask

   task automatic queue_ticks(input int count);
      cmd_type word;
      word.opcode = OP_TICK;
      for (int i = 0; i < count; i++) begin
         // Row, column and digit are don't-care on a tick; keep them moving.
         word.row    = row_type'($urandom_range(0, 1));
         word.column = 3'($urandom_range(0, 7));
         word.digit  = 4'($urandom_range(0, 15));
         pending_words.push_back(word);
      end
   endtask

   // Write a whole two-digit field, tens and units in random order.
   task automatic queue_field(input row_type row, input int slot, input int value);
      logic [2:0] tens_col;
      tens_col = 3'(3 * slot);
      if ($urandom_range(0, 1) == 1) begin
         queue_set(row, tens_col, 4'(value / 10));
         queue_set(row, tens_col + 3'd1, 4'(value % 10));
      end else begin
         queue_set(row, tens_col + 3'd1, 4'(value % 10));
         queue_set(row, tens_col, 4'(value / 10));
      end
   endtask

   task automatic build_stimulus();
      int kind;
      int mon;
      // Directed: the last second of the century wraps everything to reset.
      queue_ticks(1);
      queue_set(ROW_TIME, COL_FIRST_TENS, 4'd2);
      queue_set(ROW_TIME, COL_FIRST_UNITS, 4'd3);
      queue_set(ROW_TIME, COL_SECOND_TENS, 4'd5);
      queue_set(ROW_TIME, COL_SECOND_UNITS, 4'd9);
      queue_set(ROW_TIME, COL_THIRD_TENS, 4'd5);
      queue_set(ROW_TIME, COL_THIRD_UNITS, 4'd9);
      queue_set(ROW_DATE, COL_FIRST_TENS, 4'd1);
      queue_set(ROW_DATE, COL_FIRST_UNITS, 4'd2);
      queue_set(ROW_DATE, COL_SECOND_TENS, 4'd3);
      queue_set(ROW_DATE, COL_SECOND_UNITS, 4'd1);
      queue_set(ROW_DATE, COL_THIRD_TENS, 4'd9);
      queue_set(ROW_DATE, COL_THIRD_UNITS, 4'd9);
      queue_ticks(1);
      // Fields pushed over their maximum clamp to it; a units digit of 15 just adds 15.
      queue_set(ROW_TIME, COL_FIRST_TENS, 4'd15);
      queue_set(ROW_TIME, COL_SECOND_TENS, 4'd9);
      queue_set(ROW_TIME, COL_THIRD_UNITS, 4'd15);
      // Separator columns change nothing.
      queue_set(ROW_TIME, COL_SEP_A, 4'd7);
      queue_set(ROW_DATE, COL_SEP_B, 4'd9);
      // Zero month and zero day become one.
      queue_set(ROW_DATE, COL_FIRST_UNITS, 4'd0);
      queue_set(ROW_DATE, COL_SECOND_UNITS, 4'd0);
      // February of a leap year, then a common year shortens the day.
      queue_set(ROW_DATE, COL_FIRST_UNITS, 4'd2);
      queue_set(ROW_DATE, COL_SECOND_TENS, 4'd3);
      queue_set(ROW_DATE, COL_THIRD_UNITS, 4'd1);
      queue_set(ROW_DATE, COL_FIRST_TENS, 4'd15);

      // Random part: mostly setups just ahead of a rollover, then ticks.
      while (pending_words.size() < RANDOM_WORDS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            queue_set(row_type'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      4'(($urandom_range(0, 3) == 0) ? $urandom_range(10, 15)
                                                      : $urandom_range(0, 9)));
         end else if (kind <= 4) begin
            queue_ticks($urandom_range(1, 30));
         end else if (kind <= 7) begin
            // Near the end of a day, often at the end of a month or century.
            if ($urandom_range(0, 3) == 0) begin
               queue_field(ROW_DATE, 0, 12);
               queue_field(ROW_DATE, 2, 99);
               queue_field(ROW_DATE, 1, 31);
            end else begin
               mon = $urandom_range(1, 12);
               queue_field(ROW_DATE, 0, mon);
               queue_field(ROW_DATE, 2, $urandom_range(0, 99));
               queue_field(ROW_DATE, 1, (mon == 2) ? $urandom_range(27, 29)
                                                   : $urandom_range(28, 31));
            end
            queue_field(ROW_TIME, 0, $urandom_range(22, 23));
            queue_field(ROW_TIME, 1, 59);
            queue_field(ROW_TIME, 2, $urandom_range(45, 59));
            queue_ticks($urandom_range(5, 70));
         end else begin
            queue_field(ROW_TIME, 1, $urandom_range(0, 59));
            queue_field(ROW_TIME, 2, $urandom_range(50, 59));
            queue_ticks($urandom_range(1, 15));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: bursts of words separated by random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      cmd_type word;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else if (req_valid && !req_fire) begin
         // Hold the word until it is taken.
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
         word = pending_words.pop_front();
         req_valid  <= 1'b1;
         req_opcode <= word.opcode;
         req_row    <= word.row;
         req_column <= word.column;
         req_digit  <= word.digit;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: stall style changes from time to time
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_left   <= 0;
         style_cycles <= 0;
         rx_style     <= RX_STREAM;
      end else begin
         if (style_cycles == 0) begin
            rx_style     <= rx_style_type'($urandom_range(0, 2));
            style_cycles <= $urandom_range(50, 300);
         end else begin
            style_cycles <= style_cycles - 1;
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (rx_style == RX_JITTER && $urandom_range(0, 3) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else if (rx_style == RX_BLOCKING && $urandom_range(0, 7) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(3, 24);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      calendar_type got;
      if (reset) begin
         clock_now = CAL_RESET;
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            if (opcode_type'(req_opcode) == OP_TICK) begin
               tick_count++;
               advance_one_second();
            end else begin
               set_count++;
               apply_digit_set(row_type'(req_row), req_column, req_digit);
            end
            expected_calendars.push_back(clock_now);
         end
         if (rsp_valid && rsp_ready) begin
            got.hours   = rsp_hours;
            got.minutes = rsp_minutes;
            got.seconds = rsp_seconds;
            got.day     = rsp_day_of_month;
            got.month   = rsp_month_number;
            got.year    = rsp_year_of_century;
            check_response(got);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_clock_calendar_counter_core: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every word is sent and every response has come back.
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_calendars.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_calendars.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", expected_calendars.size()));
      end
      $display("Checked %0d response words from %0d ticks and %0d digit sets.",
               checked_words, tick_count, set_count);
      $display("Saw %0d month rollovers and %0d century wraps; %0d errors.",
               day_rollovers, year_wraps, error_count);
      if (error_count == 0) begin
         $display("tb_clock_calendar_counter_core: PASS");
      end else begin
         $display("tb_clock_calendar_counter_core: FAIL");
      end
      $finish;
   end

endmodule
